>>> rtl/core/wae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wae_pkg
// Shared constants, codes and types of the windowed alarm escalator.
// ----------------------------------------------------------------------------
package wae_pkg;

   localparam int HISTORY_SLOTS = 8;
   localparam int SLOT_IDX_BITS = $clog2(HISTORY_SLOTS);
   localparam int COUNT_BITS    = $clog2(HISTORY_SLOTS + 1);
   localparam int SIGNAL_BITS   = 32;
   localparam int TIME_BITS     = 48;
   localparam int WINDOW_BITS   = 32;
   localparam int THRESH_BITS   = 4;
   localparam int CATEGORIES    = 5;

   localparam int KIND_BITS     = 2;
   localparam int SEV_BITS      = 2;
   localparam int LATCH_BITS    = 2;
   localparam int FAULT_BITS    = 3;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // request tdata: severity, signal_mask, now_ms, zero fill to bytes
   localparam int REQ_FIELD_BITS = SEV_BITS + SIGNAL_BITS + TIME_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   // response tdata: latch_state, degrade_fired, kill_fired, fault_code, live_signals
   localparam int RSP_FIELD_BITS = LATCH_BITS + 2 + FAULT_BITS + SIGNAL_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(10 * 60 * 1000);
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(2);

   localparam logic [KIND_BITS-1:0] KIND_REPORT  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_TRIGGER = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR   = 2'd2;

   localparam logic [SEV_BITS-1:0] SEV_TELEMETRY = 2'd0;
   localparam logic [SEV_BITS-1:0] SEV_DEGRADE   = 2'd1;
   localparam logic [SEV_BITS-1:0] SEV_KILL      = 2'd2;

   localparam logic [LATCH_BITS-1:0] LATCH_NORMAL   = 2'd0;
   localparam logic [LATCH_BITS-1:0] LATCH_DEGRADED = 2'd1;
   localparam logic [LATCH_BITS-1:0] LATCH_KILLED   = 2'd2;

   localparam logic [FAULT_BITS-1:0] FAULT_NONE     = 3'd0;
   localparam logic [FAULT_BITS-1:0] FAULT_MULTIPLE = 3'd5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEGRADE_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LENGTH     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_MASK        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INJECTION_MASK    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBUG_MASK        = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAMPER_MASK       = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTEGRITY_MASK    = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic clear;
      logic write;
      logic expire;
   } hist_ctl_type;

endpackage : wae_pkg
`default_nettype wire

>>> rtl/core/wae_history.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wae_history
// Report ring with valid bits, write pointer and the shared age comparator
// that judges one slot per cycle against the window.
// ----------------------------------------------------------------------------
module wae_history
   import wae_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire hist_ctl_type             hist_ctl,
   input  wire logic [TIME_BITS-1:0]     wr_time,
   input  wire logic [SIGNAL_BITS-1:0]   wr_signal,
   input  wire logic [SLOT_IDX_BITS-1:0] rd_idx,
   input  wire logic [TIME_BITS-1:0]     now,
   input  wire logic [WINDOW_BITS-1:0]   window_length,
   output logic                          rd_live,
   output logic [SIGNAL_BITS-1:0]        rd_signal
);

   logic [HISTORY_SLOTS-1:0]     slot_valid_ff, slot_valid_in;
   logic [SLOT_IDX_BITS-1:0]     wp_ff, wp_in;
   logic [TIME_BITS-1:0]         slot_time_ff   [HISTORY_SLOTS];
   logic [SIGNAL_BITS-1:0]       slot_signal_ff [HISTORY_SLOTS];
   logic [TIME_BITS-1:0]         age;

   assign age       = now - slot_time_ff[rd_idx];
   assign rd_live   = slot_valid_ff[rd_idx] && (age <= TIME_BITS'(window_length));
   assign rd_signal = slot_signal_ff[rd_idx];

   always_comb begin
      slot_valid_in = slot_valid_ff;
      wp_in         = wp_ff;
      if (hist_ctl.clear) begin
         slot_valid_in = '0;
         wp_in         = '0;
      end else if (hist_ctl.write) begin
         slot_valid_in[wp_ff] = 1'b1;
         wp_in = (wp_ff == SLOT_IDX_BITS'(HISTORY_SLOTS - 1)) ? '0 : wp_ff + 1'b1;
      end else if (hist_ctl.expire && slot_valid_ff[rd_idx] && !rd_live) begin
         slot_valid_in[rd_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         wp_ff         <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         wp_ff         <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hist_ctl.write && !hist_ctl.clear) begin
         slot_time_ff[wp_ff]   <= wr_time;
         slot_signal_ff[wp_ff] <= wr_signal;
      end
   end

endmodule : wae_history
`default_nettype wire

>>> rtl/core/windowed_alarm_escalation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_alarm_escalation
// Security alarm escalator: records timestamped reports in a ring, counts
// live matching entries against a threshold and latches degraded or killed.
//
//   channel  dir   handshake               payload
//   req      in    req_tvalid/req_tready   tuser kind; tdata severity, signal, time
//   rsp      out   rsp_tvalid/rsp_tready   tdata latch, flags, fault code, live OR
//   csr      in    csr_valid/csr_ready     csr_index, csr_wdata
//
// The accept cycle takes the request, the scan judges one ring slot per cycle
// through the single age comparator, and a finish state registers the result.
// Next request is taken the cycle after finish; the response register holds
// a result while the next request is in work. Finish waits on a stalled rsp.
// Reset clears the ring valid bits at once; no clearing pass.
// csr writes are always accepted.
// ----------------------------------------------------------------------------
module windowed_alarm_escalation
   import wae_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [KIND_BITS-1:0]      req_tuser,  // kind
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,  // severity, signal_mask, now_ms
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,  // latch_state, degrade_fired,
                                                      // kill_fired, fault_code, live_signals
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   seq_state_type              state_ff, state_in;
   logic [SLOT_IDX_BITS-1:0]   idx_ff, idx_in;
   logic [TIME_BITS-1:0]       now_ff, now_in;
   logic [SIGNAL_BITS-1:0]     sig_ff, sig_in;
   logic                       do_degrade_ff, do_degrade_in;
   logic                       do_trigger_ff, do_trigger_in;
   logic [SIGNAL_BITS-1:0]     acc_ff, acc_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic [LATCH_BITS-1:0]      latch_ff, latch_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;

   logic [THRESH_BITS-1:0]     thresh_ff;
   logic [WINDOW_BITS-1:0]     window_ff;
   logic [SIGNAL_BITS-1:0]     cat_mask_ff [CATEGORIES];

   logic [SEV_BITS-1:0]        in_sev;
   logic [SIGNAL_BITS-1:0]     in_sig;
   logic [TIME_BITS-1:0]       in_now;
   logic                       accept;
   logic                       rep_sig, rec, trig, degr, clr;
   hist_ctl_type               hist_ctl;
   logic                       rd_live;
   logic [SIGNAL_BITS-1:0]     rd_signal;
   logic [FAULT_BITS-1:0]      fault_code;
   logic                       deg_fire, kill_fire;
   logic [LATCH_BITS-1:0]      latch_next;

   assign in_sev = req_tdata[SEV_BITS-1:0];
   assign in_sig = req_tdata[SEV_BITS +: SIGNAL_BITS];
   assign in_now = req_tdata[SEV_BITS + SIGNAL_BITS +: TIME_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rep_sig = (req_tuser == KIND_REPORT) && (in_sig != '0);
   assign rec     = rep_sig && ((in_sev == SEV_TELEMETRY) || (in_sev == SEV_DEGRADE));
   assign trig    = (rep_sig && !rec) || (req_tuser == KIND_TRIGGER);
   assign degr    = rec && (in_sev == SEV_DEGRADE) && (latch_ff == LATCH_NORMAL);
   assign clr     = (req_tuser == KIND_CLEAR) && (latch_ff != LATCH_KILLED);

   assign hist_ctl.clear  = accept && clr;
   assign hist_ctl.write  = accept && rec;
   assign hist_ctl.expire = (state_ff == ST_SCAN) && do_degrade_ff;

   wae_history u_history (
      .clock         (clock),
      .reset         (reset),
      .hist_ctl      (hist_ctl),
      .wr_time       (in_now),
      .wr_signal     (in_sig),
      .rd_idx        (idx_ff),
      .now           (now_ff),
      .window_length (window_ff),
      .rd_live       (rd_live),
      .rd_signal     (rd_signal)
   );

   // one-hot category match over the live OR
   always_comb begin
      logic [FAULT_BITS-1:0] hits;
      logic [FAULT_BITS-1:0] code;
      hits = '0;
      code = FAULT_NONE;
      for (int c = 0; c < CATEGORIES; c++) begin
         if ((acc_ff & cat_mask_ff[c]) != '0) begin
            code = FAULT_BITS'(c);
            hits = hits + 1'b1;
         end
      end
      fault_code = (hits == FAULT_BITS'(1)) ? code : FAULT_MULTIPLE;
   end

   assign deg_fire  = do_degrade_ff && (32'(count_ff) >= 32'(thresh_ff));
   assign kill_fire = do_trigger_ff && (latch_ff == LATCH_NORMAL);

   always_comb begin
      latch_next = latch_ff;
      if (kill_fire) begin
         latch_next = LATCH_KILLED;
      end else if (deg_fire) begin
         latch_next = LATCH_DEGRADED;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      now_in        = now_ff;
      sig_in        = sig_ff;
      do_degrade_in = do_degrade_ff;
      do_trigger_in = do_trigger_ff;
      acc_in        = acc_ff;
      count_in      = count_ff;
      latch_in      = latch_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in      = ST_SCAN;
               idx_in        = '0;
               now_in        = in_now;
               sig_in        = in_sig;
               do_degrade_in = degr;
               do_trigger_in = trig;
               acc_in        = '0;
               count_in      = '0;
               if (clr) begin
                  latch_in = LATCH_NORMAL;
               end
            end
         end
         ST_SCAN: begin
            if (rd_live) begin
               acc_in = acc_ff | rd_signal;
               if ((rd_signal & sig_ff) != '0) begin
                  count_in = count_ff + 1'b1;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == SLOT_IDX_BITS'(HISTORY_SLOTS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in     = ST_IDLE;
               latch_in     = latch_next;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_BITS'({acc_ff,
                                              kill_fire ? fault_code : FAULT_NONE,
                                              kill_fire, deg_fire, latch_next});
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         latch_ff     <= LATCH_NORMAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      now_ff        <= now_in;
      sig_ff        <= sig_in;
      do_degrade_ff <= do_degrade_in;
      do_trigger_ff <= do_trigger_in;
      acc_ff        <= acc_in;
      count_ff      <= count_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         window_ff <= WINDOW_RESET;
         for (int c = 0; c < CATEGORIES; c++) begin
            cat_mask_ff[c] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEGRADE_THRESHOLD: thresh_ff      <= csr_wdata[THRESH_BITS-1:0];
            CSR_WINDOW_LENGTH:     window_ff      <= csr_wdata[WINDOW_BITS-1:0];
            CSR_INDEX_MASK:        cat_mask_ff[0] <= csr_wdata[SIGNAL_BITS-1:0];
            CSR_INJECTION_MASK:    cat_mask_ff[1] <= csr_wdata[SIGNAL_BITS-1:0];
            CSR_DEBUG_MASK:        cat_mask_ff[2] <= csr_wdata[SIGNAL_BITS-1:0];
            CSR_TAMPER_MASK:       cat_mask_ff[3] <= csr_wdata[SIGNAL_BITS-1:0];
            CSR_INTEGRITY_MASK:    cat_mask_ff[4] <= csr_wdata[SIGNAL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule : windowed_alarm_escalation
`default_nettype wire

>>> rtl/core/wae_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wae_checker
// Port-level checks of the alarm escalator, bound to the top level.
// ----------------------------------------------------------------------------
module wae_checker
   import wae_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // a request transaction occupies the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a transaction is in work");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |->
         (rsp_tdata[1:0] == LATCH_KILLED) && !rsp_tdata[2])
      else $error("kill fired without killed latch");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2]) |->
         (rsp_tdata[1:0] == LATCH_DEGRADED) && (rsp_tdata[6:4] == FAULT_NONE))
      else $error("degrade fired without degraded latch or with fault code");

endmodule : wae_checker

bind windowed_alarm_escalation wae_checker u_wae_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
